/* src/cssd_pkg.sv */
package cssd_pkg;

    localparam int MAX_PATTERN_DEF = 8;
    localparam int MAX_TEXT_DEF    = 65535;

    localparam int BYTE_W      = 8;
    localparam int POS_W       = 16;
    localparam int LEN_CFG_W   = 4;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 2;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 24;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_BYTES  = 2'd0,
        REG_PATTERN_LENGTH = 2'd1
    } cfg_reg_t;

    localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_Z = 8'h7a;
    localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'h20;

    // ASCII lower case letters map to upper case, everything else unchanged
    function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] r;
        r = c;
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
        begin
            r = c - CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

/* src/cssd_front.sv */
module cssd_front #(
    parameter int MAX_PATTERN = cssd_pkg::MAX_PATTERN_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [MAX_PATTERN*cssd_pkg::BYTE_W-1:0] pattern,
    input  logic                                  in_valid,
    input  logic [cssd_pkg::BYTE_W-1:0]           in_byte,
    input  logic                                  in_last,
    input  logic                                  push_ready,
    output logic                                  push,
    output logic [MAX_PATTERN:0]                  push_data
);

    logic [cssd_pkg::BYTE_W-1:0] window_reg  [MAX_PATTERN];
    logic [cssd_pkg::BYTE_W-1:0] window_next [MAX_PATTERN];
    logic [cssd_pkg::BYTE_W-1:0] pat_fold    [MAX_PATTERN];
    logic [MAX_PATTERN-1:0]      match_vec;

    assign push = in_valid && push_ready;

    always_comb
    begin
        window_next[0] = cssd_pkg::fold_case(in_byte);
        for (int i = 1; i < MAX_PATTERN; i++)
        begin
            window_next[i] = window_reg[i-1];
        end
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            pat_fold[i] = cssd_pkg::fold_case(pattern[i*cssd_pkg::BYTE_W +: cssd_pkg::BYTE_W]);
        end
        // bit k-1: the k newest bytes, oldest first, equal the k-byte prefix
        for (int k = 1; k <= MAX_PATTERN; k++)
        begin
            match_vec[k-1] = 1'b1;
            for (int i = 0; i < k; i++)
            begin
                if (window_next[k-1-i] != pat_fold[i])
                begin
                    match_vec[k-1] = 1'b0;
                end
            end
        end
    end

    assign push_data = {in_last, match_vec};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_PATTERN; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else if (push)
        begin
            for (int i = 0; i < MAX_PATTERN; i++)
            begin
                window_reg[i] <= window_next[i];
            end
        end
    end

endmodule

/* src/cssd_queue.sv */
module cssd_queue #(
    parameter int WIDTH = cssd_pkg::MAX_PATTERN_DEF + 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             push_ready,
    input  logic             pop,
    output logic             pop_valid,
    output logic [WIDTH-1:0] pop_data
);

    localparam int DEPTH = cssd_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* src/cssd_back.sv */
module cssd_back #(
    parameter int MAX_PATTERN = cssd_pkg::MAX_PATTERN_DEF,
    parameter int MAX_TEXT    = cssd_pkg::MAX_TEXT_DEF,
    localparam int LEN_W      = $clog2(MAX_PATTERN + 1)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [LEN_W-1:0]                   used_len,
    input  logic                               q_valid,
    input  logic [MAX_PATTERN:0]               q_data,
    output logic                               q_pop,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [cssd_pkg::OUT_DATA_W-1:0]    out_data
);

    localparam int POS_W = cssd_pkg::POS_W;

    logic [LEN_W-1:0] matched_len_reg, matched_len_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             reported_reg, reported_next;
    logic [POS_W-1:0] first_end_reg, first_end_next;
    logic             out_valid_reg, out_valid_next;
    logic             found_reg, found_next;
    logic [POS_W-1:0] match_end_reg, match_end_next;

    logic [MAX_PATTERN-1:0] match_vec;
    logic                   q_last;
    logic [LEN_W:0]         m_inc;
    logic [LEN_W-1:0]       lim;
    logic [LEN_W-1:0]       cand;
    logic [POS_W-1:0]       pos_inc;
    logic                   hit_reported;
    logic [POS_W-1:0]       hit_end;

    assign match_vec = q_data[MAX_PATTERN-1:0];
    assign q_last    = q_data[MAX_PATTERN];

    // a final byte needs a free output slot
    assign q_pop = q_valid && (!q_last || !out_valid_reg || out_ready);

    always_comb
    begin
        m_inc = {1'b0, matched_len_reg} + 1'b1;
        lim   = (m_inc > {1'b0, used_len}) ? used_len : m_inc[LEN_W-1:0];
        cand  = '0;
        for (int j = 1; j <= MAX_PATTERN; j++)
        begin
            if ((LEN_W'(j) <= lim) && match_vec[j-1])
            begin
                cand = LEN_W'(j);
            end
        end
        pos_inc = (pos_reg < POS_W'(MAX_TEXT)) ? pos_reg + 1'b1 : pos_reg;

        matched_len_next = matched_len_reg;
        hit_reported     = reported_reg;
        hit_end          = first_end_reg;
        if (!reported_reg)
        begin
            matched_len_next = cand;
            if (cand == used_len)
            begin
                hit_reported = 1'b1;
                hit_end      = pos_inc;
            end
        end

        pos_next       = pos_reg;
        reported_next  = reported_reg;
        first_end_next = first_end_reg;
        found_next     = found_reg;
        match_end_next = match_end_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (q_pop)
        begin
            if (q_last)
            begin
                out_valid_next   = 1'b1;
                found_next       = hit_reported;
                match_end_next   = hit_reported ? hit_end : '0;
                matched_len_next = '0;
                pos_next         = '0;
                reported_next    = 1'b0;
                first_end_next   = '0;
            end
            else
            begin
                pos_next       = pos_inc;
                reported_next  = hit_reported;
                first_end_next = hit_end;
            end
        end
        else
        begin
            matched_len_next = matched_len_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matched_len_reg <= '0;
            pos_reg         <= '0;
            reported_reg    <= 1'b0;
            first_end_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            matched_len_reg <= matched_len_next;
            pos_reg         <= pos_next;
            reported_reg    <= reported_next;
            first_end_reg   <= first_end_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg     <= found_next;
        match_end_reg <= match_end_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {{(cssd_pkg::OUT_DATA_W - POS_W - 1){1'b0}}, match_end_reg, found_reg};

endmodule

/* src/caseless_substring_search_dfa.sv */
// Caseless substring search.
// Searches each buffer of text for the first occurrence of a pattern of
// 1 to MAX_PATTERN bytes; ASCII letters compare without regard to case.
// Input stream s_axis: one text byte per request, tlast on the buffer's last
// byte. Output stream m_axis: one result per buffer, sent for the tlast byte:
// found flag and the 1-based position of the byte ending the first match
// (0 when not found). Positions saturate at MAX_TEXT.
// Configuration: cfg_index 0 writes the pattern (first byte in bits 7:0),
// index 1 the pattern length (0 acts as 1, above MAX_PATTERN as MAX_PATTERN).
// Write only while no buffer is in flight.
// Throughput: one byte per cycle while s_axis_tready is high. After the
// tlast byte is accepted, the result passes the front compare and the queue,
// then the back state update that feeds the output register.
// When m_axis stalls, bytes keep flowing into the back until a tlast byte
// has to wait for the output register; the two-entry queue then fills and
// s_axis_tready drops. Reset clears the control, window and pointer registers
// (not the result data or queue storage); pattern resets to 0, length to 1.
module caseless_substring_search_dfa #(
    parameter int MAX_PATTERN = cssd_pkg::MAX_PATTERN_DEF,
    parameter int MAX_TEXT    = cssd_pkg::MAX_TEXT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wen,
    input  logic [cssd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [cssd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [cssd_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // [7:0] text_byte
    input  logic                                s_axis_tlast,  // last_byte
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [cssd_pkg::OUT_DATA_W-1:0]     m_axis_tdata   // [0] found, [16:1] match_end
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int PAT_W = MAX_PATTERN * cssd_pkg::BYTE_W;

    logic [cssd_pkg::CFG_DATA_W-1:0] pattern_bytes_reg;
    logic [cssd_pkg::LEN_CFG_W-1:0]  pattern_length_reg;
    logic [LEN_W-1:0]                used_len;

    logic                   push;
    logic                   push_ready;
    logic [MAX_PATTERN:0]   push_data;
    logic                   q_pop;
    logic                   q_valid;
    logic [MAX_PATTERN:0]   q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg  <= '0;
            pattern_length_reg <= cssd_pkg::LEN_CFG_W'(1);
        end
        else if (cfg_wen)
        begin
            unique case (cssd_pkg::cfg_reg_t'(cfg_index))
                cssd_pkg::REG_PATTERN_BYTES:  pattern_bytes_reg  <= cfg_data;
                cssd_pkg::REG_PATTERN_LENGTH:
                    pattern_length_reg <= cfg_data[cssd_pkg::LEN_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (pattern_length_reg == '0)
        begin
            used_len = LEN_W'(1);
        end
        else if (pattern_length_reg > cssd_pkg::LEN_CFG_W'(MAX_PATTERN))
        begin
            used_len = LEN_W'(MAX_PATTERN);
        end
        else
        begin
            used_len = LEN_W'(pattern_length_reg);
        end
    end

    cssd_front #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pattern    (pattern_bytes_reg[PAT_W-1:0]),
        .in_valid   (s_axis_tvalid),
        .in_byte    (s_axis_tdata[cssd_pkg::BYTE_W-1:0]),
        .in_last    (s_axis_tlast),
        .push_ready (push_ready),
        .push       (push),
        .push_data  (push_data)
    );

    cssd_queue #(
        .WIDTH (MAX_PATTERN + 1)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_data   (q_data)
    );

    cssd_back #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_TEXT    (MAX_TEXT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .used_len  (used_len),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

    assign s_axis_tready = push_ready;

`ifndef ASSERT_OFF
    a_stall_means_queued: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> q_valid)
        else $error("input stalled with empty queue");

    a_not_found_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[16:1] == '0)
        else $error("match_end nonzero without a match");

    a_found_has_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[16:1] != '0)
        else $error("match reported at position zero");
`endif

endmodule

/* bench/caseless_substring_search_dfa_test.sv */
`timescale 1ns / 1ps

module caseless_substring_search_dfa_test;

    localparam int DRAIN_CYCLES = 4;
    localparam int RANDOM_ITEMS = 440;
    localparam logic [cssd_pkg::CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [cssd_pkg::CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct packed {
        logic        found;
        logic [15:0] match_end;
    } search_result_t;

    typedef enum logic {ROW_WRITE, ROW_BYTE} row_kind_t;

    typedef struct packed {
        row_kind_t                          kind;
        logic [cssd_pkg::CFG_INDEX_W-1:0]   idx;
        logic [cssd_pkg::CFG_DATA_W-1:0]    data;
        logic [7:0]                         text;
        logic                               last;
        bit                                 fixed;
        search_result_t                     want;
    } script_row_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 cfg_wen = 1'b0;
    logic [cssd_pkg::CFG_INDEX_W-1:0]     cfg_index = '0;
    logic [cssd_pkg::CFG_DATA_W-1:0]      cfg_data = '0;
    logic                                 s_axis_tvalid = 1'b0;
    logic                                 s_axis_tready;
    logic [cssd_pkg::IN_DATA_W-1:0]       s_axis_tdata = '0;   // [7:0] text_byte
    logic                                 s_axis_tlast = 1'b0; // last_byte
    logic                                 m_axis_tvalid;
    logic                                 m_axis_tready = 1'b0;
    logic [cssd_pkg::OUT_DATA_W-1:0]      m_axis_tdata;  // [0] found, [16:1] match_end

    // search model state
    logic [63:0]    pat_bytes = '0;
    logic [3:0]     pat_len_reg = 4'd1;
    int             prefix_len = 0;
    logic [15:0]    text_pos = '0;
    bit             hit_seen = 1'b0;
    logic [15:0]    hit_pos = '0;
    logic [7:0]     window [0:7];

    search_result_t pending_results[$];
    script_row_t    script[$];
    search_result_t want_res;
    int             mismatch_count = 0;
    int             random_items = 0;
    bit             no_gaps = 1'b0;

    caseless_substring_search_dfa u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(20_000_000);
        $display("Mismatches found");
        $finish;
    end

    function automatic logic [7:0] upcase_byte(input logic [7:0] c);
        if (c >= 8'h61 && c <= 8'h7a)
        begin
            return c - 8'h20;
        end
        return c;
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
    endfunction

    function automatic logic [7:0] mixed_case(input logic [7:0] c);
        if (is_letter(c) && $urandom_range(0, 1) == 1)
        begin
            return c ^ 8'h20;
        end
        return c;
    endfunction

    // small alphabet (a to c), random bytes, 00, ff and the bytes bordering the letter ranges, so
    // partial matches and case folding edges come up often
    function automatic logic [7:0] noise_byte();
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0: c = 8'($urandom_range(0, 255));
            1:
            begin
                case ($urandom_range(0, 5))
                    0: c = 8'h40;
                    1: c = 8'h5b;
                    2: c = 8'h60;
                    3: c = 8'h7b;
                    4: c = 8'h00;
                    default: c = 8'hff;
                endcase
            end
            default: c = mixed_case(8'(8'h61 + $urandom_range(0, 2)));
        endcase
        return c;
    endfunction

    function automatic int pattern_span();
        if (pat_len_reg == 0)
        begin
            return 1;
        end
        if (pat_len_reg > 8)
        begin
            return 8;
        end
        return int'(pat_len_reg);
    endfunction

    task automatic advance_text(input logic [7:0] c, input logic last,
                                output bit done, output search_result_t res);
        int span;
        int k;
        int i;
        bit ok;
        span = pattern_span();
        done = 1'b0;
        res = '0;
        if (text_pos != 16'hffff)
        begin
            text_pos++;
        end
        for (i = 7; i > 0; i--)
        begin
            window[i] = window[i-1];
        end
        window[0] = c;
        if (!hit_seen)
        begin
            k = prefix_len + 1;
            if (k > span)
            begin
                k = span;
            end
            ok = 1'b0;
            while (k > 0 && !ok)
            begin
                ok = 1'b1;
                for (i = 0; i < k; i++)
                begin
                    if (upcase_byte(window[k-1-i]) != upcase_byte(pat_bytes[8*i +: 8]))
                    begin
                        ok = 1'b0;
                    end
                end
                if (!ok)
                begin
                    k--;
                end
            end
            prefix_len = k;
            if (prefix_len == span)
            begin
                hit_seen = 1'b1;
                hit_pos = text_pos;
            end
        end
        if (last)
        begin
            done = 1'b1;
            res.found = hit_seen;
            res.match_end = hit_seen ? hit_pos : 16'd0;
            prefix_len = 0;
            text_pos = '0;
            hit_seen = 1'b0;
            hit_pos = '0;
        end
    endtask

    task automatic write_reg(input logic [cssd_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [63:0] data);
        @(negedge clk);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            cssd_pkg::REG_PATTERN_BYTES:  pat_bytes = data;
            cssd_pkg::REG_PATTERN_LENGTH: pat_len_reg = data[3:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_wen <= 1'b0;
    endtask

    task automatic send_byte(input logic [7:0] c, input logic last,
                             input bit fixed, input search_result_t want);
        int gap;
        bit done;
        search_result_t res;
        gap = no_gaps ? 0 : $urandom_range(0, 11);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= c;
        s_axis_tlast <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        advance_text(c, last, done, res);
        if (done)
        begin
            pending_results.push_back(fixed ? want : res);
        end
    endtask

    // stop sending, let every expected result arrive and the pipe empty
    task automatic settle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() > 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic add_write(input logic [cssd_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [63:0] data);
        script_row_t row;
        row = '0;
        row.kind = ROW_WRITE;
        row.idx = idx;
        row.data = data;
        script.push_back(row);
    endtask

    task automatic add_byte(input logic [7:0] c);
        script_row_t row;
        row = '0;
        row.kind = ROW_BYTE;
        row.text = c;
        script.push_back(row);
    endtask

    task automatic add_final(input logic [7:0] c, input logic found, input logic [15:0] pos);
        script_row_t row;
        row = '0;
        row.kind = ROW_BYTE;
        row.text = c;
        row.last = 1'b1;
        row.fixed = 1'b1;
        row.want.found = found;
        row.want.match_end = pos;
        script.push_back(row);
    endtask

    task automatic random_buffer();
        logic [7:0] text_q[$];
        int n;
        int span;
        int cut;
        int start;
        int i;
        span = pattern_span();
        n = $urandom_range(1, 20);
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                text_q.push_back(mixed_case(pat_bytes[8*$urandom_range(0, span-1) +: 8]));
            end
            else
            begin
                text_q.push_back(noise_byte());
            end
        end
        if ($urandom_range(0, 2) != 0)
        begin
            cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, span) : span;
            start = $urandom_range(0, n-1);
            for (i = 0; i < cut && start + i < n; i++)
            begin
                text_q[start+i] = mixed_case(pat_bytes[8*i +: 8]);
            end
        end
        for (i = 0; i < n; i++)
        begin
            send_byte(text_q[i], i == n-1, 1'b0, '0);
            random_items++;
        end
    endtask

    // long buffer with a run of z's ending at stop; filler never folds to Z
    task automatic long_buffer(input int total, input int stop);
        logic [7:0] c;
        int p;
        for (p = 1; p <= total; p++)
        begin
            if (p > stop - 8 && p <= stop)
            begin
                c = mixed_case(8'h7a);
            end
            else
            begin
                c = noise_byte();
                if (upcase_byte(c) == 8'h5a)
                begin
                    c = 8'h00;
                end
            end
            send_byte(c, p == total, 1'b0, '0);
        end
    endtask

    task automatic random_config();
        logic [63:0] data;
        int i;
        if ($urandom_range(0, 3) != 0)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                data = {$urandom, $urandom};
            end
            else
            begin
                for (i = 0; i < 8; i++)
                begin
                    data[8*i +: 8] = noise_byte();
                end
            end
            write_reg(cssd_pkg::REG_PATTERN_BYTES, data);
        end
        if ($urandom_range(0, 3) != 0)
        begin
            data = {$urandom, $urandom};
            case ($urandom_range(0, 9))
                0: data[3:0] = 4'd0;
                1: data[3:0] = 4'($urandom_range(9, 15));
                default: data[3:0] = 4'($urandom_range(1, 8));
            endcase
            write_reg(cssd_pkg::REG_PATTERN_LENGTH, data);
        end
        if ($urandom_range(0, 7) == 0)
        begin
            write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, {$urandom, $urandom});
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with none expected: tdata %h", m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                want_res = pending_results.pop_front();
                if (m_axis_tdata[0] !== want_res.found)
                begin
                    $error("found: expected %0d, actual %0d", want_res.found, m_axis_tdata[0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[16:1] !== want_res.match_end)
                begin
                    $error("match_end: expected %0d, actual %0d",
                           want_res.match_end, m_axis_tdata[16:1]);
                    mismatch_count++;
                end
            end
        end
    end

    // result side: random stall before each result, none while no_gaps is set
    initial
    begin
        int stall;
        @(negedge clk);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 11);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            @(negedge clk);
        end
    end

    initial
    begin
        int i;
        int stop;
        for (i = 0; i < 8; i++)
        begin
            window[i] = '0;
        end

        // reset pattern is one zero byte
        add_final(8'h00, 1'b1, 16'd1);
        add_final(8'hff, 1'b0, 16'd0);
        // "aBc"; spare indexes must be ignored; bytes after the match absorbed
        add_write(cssd_pkg::REG_PATTERN_BYTES, 64'h0000_0000_0063_4261);
        add_write(cssd_pkg::REG_PATTERN_LENGTH, 64'd3);
        add_write(REG_SPARE_A, '1);
        add_write(REG_SPARE_B, '1);
        add_byte("x");
        add_byte("A");
        add_byte("b");
        add_byte("C");
        add_final("a", 1'b1, 16'd4);
        // "aab": a failed third byte falls back to a shorter prefix
        add_write(cssd_pkg::REG_PATTERN_BYTES, 64'h0000_0000_0062_6161);
        add_byte("A");
        add_byte("a");
        add_byte("A");
        add_final("b", 1'b1, 16'd4);
        // length 0 acts as 1
        add_write(cssd_pkg::REG_PATTERN_LENGTH, 64'd0);
        add_write(cssd_pkg::REG_PATTERN_BYTES, '1);
        add_byte("x");
        add_final(8'hff, 1'b1, 16'd2);
        // length 15 acts as 8; zero bytes compare exactly
        add_write(cssd_pkg::REG_PATTERN_LENGTH, '1);
        add_write(cssd_pkg::REG_PATTERN_BYTES, 64'h7100_5100_7100_5100);
        add_byte(8'h00);
        add_byte("q");
        add_byte(8'h00);
        add_byte("Q");
        add_byte(8'h00);
        add_byte("q");
        add_byte(8'h00);
        add_final("Q", 1'b1, 16'd8);
        // length cut from 4 to 2 inside a buffer
        add_write(cssd_pkg::REG_PATTERN_BYTES, 64'h0000_0000_6463_6261);
        add_write(cssd_pkg::REG_PATTERN_LENGTH, 64'd4);
        add_byte("a");
        add_byte("b");
        add_byte("a");
        add_write(cssd_pkg::REG_PATTERN_LENGTH, 64'd2);
        add_final("B", 1'b1, 16'd4);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[r])
        begin
            if (script[r].kind == ROW_WRITE)
            begin
                settle();
                write_reg(script[r].idx, script[r].data);
            end
            else
            begin
                send_byte(script[r].text, script[r].last, script[r].fixed, script[r].want);
            end
        end

        while (random_items < RANDOM_ITEMS)
        begin
            settle();
            no_gaps = ($urandom_range(0, 4) == 0);
            random_config();
            repeat ($urandom_range(2, 5)) random_buffer();
        end

        // full-length pattern: match ends with the run of Z's, trailing bytes absorbed
        settle();
        no_gaps = 1'b1;
        write_reg(cssd_pkg::REG_PATTERN_BYTES, {8{8'h5a}});
        write_reg(cssd_pkg::REG_PATTERN_LENGTH, 64'd8);
        long_buffer(48, 40);
        stop = $urandom_range(9, 30);
        long_buffer(stop + $urandom_range(0, 5), stop);

        settle();
        repeat (10) @(negedge clk);
        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
